// ----- rtl/rov_pkg.sv -----
// ----------------------------------------------------------------------------
// rov_pkg: route origin validator shared types
// Transaction structs, verdict codes and the prefix helpers used by the
// top level and by every table cell.
// ----------------------------------------------------------------------------
package rov_pkg;

    typedef enum logic [1:0] {
        VERDICT_UNKNOWN = 2'd0,
        VERDICT_ACCEPT  = 2'd1,
        VERDICT_REJECT  = 2'd2,
        VERDICT_FAIL    = 2'd3
    } t_verdict;

    typedef enum logic {
        OP_LOAD     = 1'b0,
        OP_VALIDATE = 1'b1
    } t_op;

    // table depth; index and count widths below are sized for it
    localparam int          TABLE_ENTRIES = 64;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned LEN_W     = 8;
    localparam int unsigned ASN_W     = 32;
    localparam int unsigned COUNT_W   = 7;
    localparam int unsigned ADDR_W    = 128;
    localparam logic [LEN_W-1:0] MAX_LEN_V4 = 8'd32;
    localparam logic [LEN_W-1:0] MAX_LEN_V6 = 8'd128;

    // input transaction
    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   entry_index;
        logic               is_ipv6;
        logic [63:0]        addr_high;
        logic [63:0]        addr_low;
        logic [LEN_W-1:0]   prefix_length;
        logic [ASN_W-1:0]   as_number;
        logic               has_as_path;
    } t_in;

    // result transaction
    typedef struct packed {
        t_verdict           verdict;
        logic [IDX_W-1:0]   decided_index;
    } t_out;

    // table write, broadcast to all cells
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic               fam;
        logic [ADDR_W-1:0]  addr;
        logic [LEN_W-1:0]   len;
        logic [ASN_W-1:0]   asn;
    } t_load;

    // prefix under validation, held steady during a walk
    typedef struct packed {
        logic               fam;
        logic [ADDR_W-1:0]  addr;
        logic [LEN_W-1:0]   plen;
        logic [ASN_W-1:0]   asn;
    } t_query;

    // token handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic               decided;
        t_verdict           verdict;
        logic [IDX_W-1:0]   idx;
    } t_token;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                   input logic fam);
        logic [LEN_W-1:0] max_len;
        max_len = fam ? MAX_LEN_V6 : MAX_LEN_V4;
        return (len > max_len) ? max_len : len;
    endfunction

    // ones in the top m bits of the 128-bit address
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] m);
        return ~({ADDR_W{1'b1}} >> m);
    endfunction

endpackage

// ----- rtl/route_origin_validator.sv -----
// ----------------------------------------------------------------------------
// route_origin_validator: route origin validation against a loaded table
// A row of table cells; a validate transaction walks the row as a token.
// ----------------------------------------------------------------------------
// Loads: a load writes the addressed cell and gives no result. A validate
//   result is offered once the token has left the last cell of the row.
// Flow: one transaction in flight; the next validate waits for the token
//   walk through the cell row and for a ready sink to take the result.
// Reset: synchronous active low; clears entry_count, the token path and the
//   control FSM. Table contents are undefined until loaded.
module route_origin_validator
    import rov_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration: entry_count
    input  logic                i_cfg_we,
    input  logic [COUNT_W-1:0]  i_cfg_wdata,
    // input transactions
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in                 i_in_data,
    // result transactions
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out                o_out_data
);

    // S_IDLE: takes loads and validates; S_WALK: token in the cell row;
    // S_OUT: verdict held until the sink takes it.
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [COUNT_W-1:0] r_count;
    t_token             r_tok_inj;
    t_out               r_out;
    logic               r_out_valid;
    t_query             r_query;

    logic               w_in_acc;
    t_load              w_load;
    t_token             w_tok [TABLE_ENTRIES+1];

    assign w_in_acc = i_in_valid && o_in_ready;

    // configuration register; the user must write it only while idle, the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    // a load goes straight to the addressed cell in the accept cycle
    always_comb begin
        w_load.en   = w_in_acc && (i_in_data.op == OP_LOAD);
        w_load.idx  = i_in_data.entry_index;
        w_load.fam  = i_in_data.is_ipv6;
        w_load.addr = {i_in_data.addr_high, i_in_data.addr_low};
        w_load.len  = i_in_data.prefix_length;
        w_load.asn  = i_in_data.as_number;
    end

    // query payload, held for the whole walk. IPv4 never looks past bit 32
    // from the top since both lengths are clamped to 32.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in_data.op == OP_VALIDATE)) begin
            r_query.fam  <= i_in_data.is_ipv6;
            r_query.addr <= {i_in_data.addr_high, i_in_data.addr_low};
            r_query.plen <= clamp_len(i_in_data.prefix_length, i_in_data.is_ipv6);
            r_query.asn  <= i_in_data.as_number;
        end
    end

    // control FSM with token injection and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tok_inj   <= '0;
            r_out       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_in_data.op == OP_VALIDATE)) begin
                        // missing AS path: token enters already decided as
                        // fail and no cell touches it
                        r_tok_inj.valid   <= 1'b1;
                        r_tok_inj.decided <= !i_in_data.has_as_path;
                        r_tok_inj.verdict <= i_in_data.has_as_path ? VERDICT_UNKNOWN
                                                                   : VERDICT_FAIL;
                        r_tok_inj.idx     <= '0;
                        r_state           <= S_WALK;
                    end
                end
                S_WALK: begin
                    // token is a one-cycle pulse into the first cell
                    r_tok_inj.valid <= 1'b0;
                    if (w_tok[TABLE_ENTRIES].valid) begin
                        r_out.verdict       <= w_tok[TABLE_ENTRIES].verdict;
                        r_out.decided_index <= w_tok[TABLE_ENTRIES].idx;
                        r_out_valid         <= 1'b1;
                        r_state             <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_tok_inj.valid <= 1'b0;
                    r_out_valid     <= 1'b0;
                    r_state         <= S_IDLE;
                end
            endcase
        end
    end

    // cell row: token moves one entry per cycle, first deciding entry wins
    assign w_tok[0] = r_tok_inj;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        rov_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_load),
            .i_query (r_query),
            .i_count (r_count),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/rov_cell.sv -----
// ----------------------------------------------------------------------------
// rov_cell: one table entry of the validator chain
// Holds one authorization, checks the passing token against it and hands
// the token to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module rov_cell
    import rov_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_load               i_load,
    input  t_query              i_query,
    input  logic [COUNT_W-1:0]  i_count,
    input  t_token              i_tok,
    output t_token              o_tok
);

    logic               r_fam;
    logic [ADDR_W-1:0]  r_addr;
    logic [LEN_W-1:0]   r_len;
    logic [ASN_W-1:0]   r_asn;
    t_token             r_tok;
    t_token             n_tok;

    logic               w_in_use;
    logic [LEN_W-1:0]   w_min_len;
    logic               w_match;

    // entry storage; length is clamped on the way in
    always_ff @(posedge i_clk) begin
        if (i_load.en && (32'(i_load.idx) == 32'(CELL_IDX))) begin
            r_fam  <= i_load.fam;
            r_addr <= i_load.addr;
            r_len  <= clamp_len(i_load.len, i_load.fam);
            r_asn  <= i_load.asn;
        end
    end

    assign w_in_use  = 32'(i_count) > 32'(CELL_IDX);
    assign w_min_len = (i_query.plen < r_len) ? i_query.plen : r_len;
    assign w_match   = ((i_query.addr ^ r_addr) & prefix_mask(w_min_len)) == '0;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.decided && w_in_use &&
            (r_fam == i_query.fam) && w_match) begin
            if (i_query.plen > r_len) begin
                n_tok.decided = 1'b1;
                n_tok.verdict = VERDICT_REJECT;
                n_tok.idx     = IDX_W'(CELL_IDX);
            end else if (i_query.plen == r_len) begin
                n_tok.decided = 1'b1;
                n_tok.verdict = (i_query.asn == r_asn) ? VERDICT_ACCEPT : VERDICT_REJECT;
                n_tok.idx     = IDX_W'(CELL_IDX);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- rtl/rov_checker.sv -----
// ----------------------------------------------------------------------------
// rov_checker: port-level checks for route_origin_validator
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module rov_checker
    import rov_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  t_out                o_out_data
);

    // held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // one transaction in flight: no intake while a result is pending
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while result pending");

    // neither a load nor a validate yields a result in the next cycle
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_out_valid)
        else $error("result right after acceptance");

    // fail and unknown carry index zero
    a_undecided_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.verdict == VERDICT_FAIL ||
                        o_out_data.verdict == VERDICT_UNKNOWN)
        |-> o_out_data.decided_index == '0)
        else $error("nonzero index on undecided verdict");

endmodule

bind route_origin_validator rov_checker u_rov_checker (.*);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for route_origin_validator
// Loads authorization tables, validates prefixes against them and checks
// every verdict against an in-bench prediction, under random source gaps
// and sink stalls, across several entry_count settings.
// ----------------------------------------------------------------------------
module tb;
    import rov_pkg::*;

    localparam int PHASE_ITEMS    = 78;
    // A load gives no result; this many quiet cycles makes the block
    // idle before an entry_count write.
    localparam int SETTLE_CYCLES  = 8;
    // Longest correct quiet stretch is a token walk plus gap, stall and
    // settle time; the limit leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;

    // one queued stimulus step: an input transaction or an entry_count write
    typedef struct {
        bit                 is_cfg;
        logic [COUNT_W-1:0] count;
        bit                 calm;
        t_in                item;
    } t_stim;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    t_in                in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_out               out_data;

    // pending stimulus and verdicts still owed by the block
    t_stim stim_q[$];
    t_out  pending_verdicts[$];

    // predicted table, updated as loads are accepted, and entry_count as written
    bit           roa_fam  [0:TABLE_ENTRIES-1];
    logic [127:0] roa_addr [0:TABLE_ENTRIES-1];
    logic [7:0]   roa_len  [0:TABLE_ENTRIES-1];
    logic [31:0]  roa_asn  [0:TABLE_ENTRIES-1];
    logic [COUNT_W-1:0] roa_count = '0;

    // table as the stimulus generator has queued it, used to aim validations
    bit           gen_fam  [0:TABLE_ENTRIES-1];
    logic [127:0] gen_addr [0:TABLE_ENTRIES-1];
    logic [7:0]   gen_len  [0:TABLE_ENTRIES-1];
    logic [31:0]  gen_asn  [0:TABLE_ENTRIES-1];

    logic [127:0] base_addr [0:1][0:3];
    logic [31:0]  asn_pool  [0:7];

    bit calm = 1'b0;     // no idling on either side during this phase
    int gap = 0;
    int settle = 0;
    int stall = 0;
    int errors = 0;
    int n_loads = 0;
    int n_checks = 0;
    int n_settings = 0;
    int verdict_seen [0:3] = '{default: 0};

    always #5 clk = ~clk;

    route_origin_validator uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // ------------------------------------------------------------------------
    // helpers shared by prediction and stimulus
    // ------------------------------------------------------------------------

    // ones in the top m bits of a 128-bit address
    function automatic logic [127:0] len_mask(input logic [7:0] m);
        if (m == 8'd0)
            return '0;
        return {128{1'b1}} << (8'd128 - m);
    endfunction

    // lengths beyond the family maximum count as the maximum
    function automatic int fit_len(input int len, input bit fam);
        int maxl;
        maxl = fam ? int'(MAX_LEN_V6) : int'(MAX_LEN_V4);
        return (len > maxl) ? maxl : len;
    endfunction

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------------
    // prediction: a load updates the table, a validate walks it in order
    // ------------------------------------------------------------------------
    function automatic bit predict_route(input t_in it, output t_out res);
        logic [127:0] qa, ea, mk;
        int qlen, elen, m, n;
        bit found;
        res.verdict       = VERDICT_UNKNOWN;
        res.decided_index = '0;
        if (it.op == OP_LOAD) begin
            roa_fam[it.entry_index]  = it.is_ipv6;
            roa_addr[it.entry_index] = {it.addr_high, it.addr_low};
            roa_len[it.entry_index]  = it.prefix_length;
            roa_asn[it.entry_index]  = it.as_number;
            return 1'b0;
        end
        if (!it.has_as_path) begin
            res.verdict = VERDICT_FAIL;   // table is not walked
            return 1'b1;
        end
        // IPv4 uses only addr_high[63:32]; the mask below never reaches further
        qa    = {it.addr_high, it.is_ipv6 ? it.addr_low : 64'd0};
        qlen  = fit_len(int'(it.prefix_length), it.is_ipv6);
        n     = (int'(roa_count) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(roa_count);
        found = 1'b0;
        for (int i = 0; i < n && !found; i++) begin
            if (roa_fam[i] != it.is_ipv6)
                continue;
            elen = fit_len(int'(roa_len[i]), roa_fam[i]);
            ea   = {roa_addr[i][127:64], it.is_ipv6 ? roa_addr[i][63:0] : 64'd0};
            m    = (qlen < elen) ? qlen : elen;
            mk   = len_mask(8'(m));
            if (((qa ^ ea) & mk) != '0)
                continue;                 // unrelated entry
            if (qlen > elen) begin
                res.verdict       = VERDICT_REJECT;
                res.decided_index = IDX_W'(i);
                found             = 1'b1;
            end else if (qlen == elen) begin
                res.verdict       = (it.as_number == roa_asn[i]) ? VERDICT_ACCEPT
                                                                 : VERDICT_REJECT;
                res.decided_index = IDX_W'(i);
                found             = 1'b1;
            end
            // a shorter prefix keeps walking
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus queueing
    // ------------------------------------------------------------------------
    task automatic push_load(input int idx, input bit fam, input logic [127:0] a,
                             input int len, input logic [31:0] asn);
        t_stim s;
        s.is_cfg                 = 1'b0;
        s.count                  = '0;
        s.calm                   = 1'b0;
        s.item.op                = OP_LOAD;
        s.item.entry_index       = IDX_W'(idx);
        s.item.is_ipv6           = fam;
        s.item.addr_high         = a[127:64];
        s.item.addr_low          = a[63:0];
        s.item.prefix_length     = LEN_W'(len);
        s.item.as_number         = asn;
        s.item.has_as_path       = 1'($urandom_range(0, 1));
        gen_fam[idx]  = fam;
        gen_addr[idx] = a;
        gen_len[idx]  = 8'(len);
        gen_asn[idx]  = asn;
        stim_q.push_back(s);
    endtask

    task automatic push_check(input bit fam, input logic [127:0] a, input int len,
                              input logic [31:0] asn, input bit path);
        t_stim s;
        s.is_cfg                 = 1'b0;
        s.count                  = '0;
        s.calm                   = 1'b0;
        s.item.op                = OP_VALIDATE;
        s.item.entry_index       = IDX_W'($urandom);
        s.item.is_ipv6           = fam;
        s.item.addr_high         = a[127:64];
        s.item.addr_low          = a[63:0];
        s.item.prefix_length     = LEN_W'(len);
        s.item.as_number         = asn;
        s.item.has_as_path       = path;
        stim_q.push_back(s);
    endtask

    task automatic push_count(input int cnt);
        t_stim s;
        s.is_cfg = 1'b1;
        s.count  = COUNT_W'(cnt);
        s.calm   = ($urandom_range(0, 3) == 0);
        s.item   = '0;
        stim_q.push_back(s);
    endtask

    // entries cluster on a few base addresses so that walks find relatives
    task automatic push_random_load(input int idx);
        bit fam;
        int maxl, s, len;
        logic [127:0] a;
        logic [31:0] asn;
        fam  = 1'($urandom_range(0, 1));
        maxl = fam ? 128 : 32;
        s    = $urandom_range(0, maxl);
        a    = (base_addr[fam][$urandom_range(0, 3)] & len_mask(8'(s)))
             | (rand128() & ~len_mask(8'(s)));
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(maxl + 1, 255)
                                           : $urandom_range(0, maxl);
        asn  = ($urandom_range(0, 9) < 7) ? asn_pool[$urandom_range(0, 7)] : $urandom;
        push_load(idx, fam, a, len, asn);
    endtask

    // ------------------------------------------------------------------------
    // source: one transaction or one entry_count write at a time
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : source
        logic               nxt_valid;
        t_in                nxt_data;
        logic               nxt_we;
        logic [COUNT_W-1:0] nxt_wdata;
        t_stim              head;
        nxt_valid = in_valid;
        nxt_data  = in_data;
        nxt_we    = 1'b0;
        nxt_wdata = cfg_wdata;
        if (!rst_n) begin
            nxt_valid = 1'b0;
            gap       = 0;
            settle    = 0;
        end else begin
            if (in_valid && in_ready) begin
                nxt_valid = 1'b0;
                gap       = calm ? 0 : $urandom_range(0, 6);
            end
            // count quiet cycles with nothing owed and nothing offered
            if (in_valid || pending_verdicts.size() != 0)
                settle = 0;
            else if (settle < SETTLE_CYCLES)
                settle++;
            if (!nxt_valid && stim_q.size() != 0) begin
                if (gap > 0) begin
                    gap--;
                end else if (!stim_q[0].is_cfg) begin
                    head      = stim_q.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data  = head.item;
                end else if (settle >= SETTLE_CYCLES) begin
                    // block is idle: the register write lands at the next edge
                    head      = stim_q.pop_front();
                    nxt_we    = 1'b1;
                    nxt_wdata = head.count;
                    roa_count = head.count;
                    calm      = head.calm;
                    settle    = 0;
                    n_settings++;
                end
            end
        end
        in_valid  <= nxt_valid;
        in_data   <= nxt_data;
        cfg_we    <= nxt_we;
        cfg_wdata <= nxt_wdata;
    end

    // predict at every accepted input transaction
    always @(posedge clk) begin : predictor_tap
        t_out res;
        if (rst_n && in_valid && in_ready) begin
            if (predict_route(in_data, res))
                pending_verdicts.push_back(res);
            if (in_data.op == OP_LOAD)
                n_loads++;
            else
                n_checks++;
        end
    end

    // ------------------------------------------------------------------------
    // sink: random stalls, each verdict checked against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : sink
        t_out want;
        if (!rst_n) begin
            stall = 0;
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (pending_verdicts.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected verdict %0d index %0d, none expected",
                             $realtime, out_data.verdict, out_data.decided_index);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (out_data.verdict !== want.verdict) begin
                        errors++;
                        $display("%0t: verdict expected %0d actual %0d", $realtime,
                                 want.verdict, out_data.verdict);
                    end
                    if (out_data.decided_index !== want.decided_index) begin
                        errors++;
                        $display("%0t: decided_index expected %0d actual %0d", $realtime,
                                 want.decided_index, out_data.decided_index);
                    end
                end
                if (!$isunknown(out_data.verdict))
                    verdict_seen[out_data.verdict]++;
                stall = calm ? 0 : $urandom_range(0, 6);
            end
            if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transaction or register write
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: %0d cycles without a transaction", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus plan and end of run
    // ------------------------------------------------------------------------
    initial begin : plan
        int phase_counts [0:9];
        int n_use, pick, e, maxl, el, ql, mode, flip;
        bit fam;
        logic [127:0] qa;
        logic [31:0] asn;

        phase_counts = '{64, 127, 1, 0, 65, 17, 64, 100, 40, 64};
        for (int f = 0; f < 2; f++)
            for (int k = 0; k < 4; k++)
                base_addr[f][k] = rand128();
        asn_pool[0] = 32'd0;
        asn_pool[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < 8; k++)
            asn_pool[k] = $urandom;

        // --- directed part ---
        // empty table after reset: unknown; no AS path: fail
        push_check(1'b0, {32'h0A00_0000, 96'h0}, 8, 32'd65000, 1'b1);
        push_check(1'b0, {32'h0A00_0000, 96'h0}, 8, 32'd65000, 1'b0);
        // IPv6 entry first so IPv4 walks must skip it
        push_load(0, 1'b1, {32'h2001_0DB8, 96'h0}, 32, 32'd100);
        // host bits and unused IPv4 bits set in the stored address
        push_load(1, 1'b0, {32'h0A01_0203, 32'hDEAD_BEEF, 64'hFFFF_0000_1234_5678},
                  8, 32'd65000);
        push_load(2, 1'b0, {32'hC0A8_0000, 96'h0}, 16, 32'hFFFF_FFFF);
        push_load(3, 1'b0, {32'h0102_0304, 96'h0}, 200, 32'd7);   // clamps to /32
        push_load(4, 1'b1, {48'h2001_0DB8_0001, 80'h0}, 48, 32'd200);
        push_load(5, 1'b1, {128{1'b1}}, 128, 32'd0);
        push_count(6);
        push_check(1'b0, {32'h0A00_0000, 96'h0}, 8, 32'd65000, 1'b1);  // exact match
        push_check(1'b0, {32'h0A00_0000, 96'h0}, 8, 32'd1, 1'b1);      // wrong origin
        push_check(1'b0, {32'h0A05_0000, 96'h0}, 16, 32'd65000, 1'b1); // too specific
        push_check(1'b0, {32'h0A00_0000, 96'h0}, 4, 32'd65000, 1'b1);  // more general
        push_check(1'b0, 128'h0, 0, 32'd0, 1'b1);
        push_check(1'b0, {32'h0102_0304, 96'h0}, 255, 32'd7, 1'b1);    // long length
        push_check(1'b0, {32'hC0A8_FFFF, {96{1'b1}}}, 16, 32'hFFFF_FFFF, 1'b1);
        push_check(1'b1, {32'h2001_0DB8, 96'h0}, 32, 32'd100, 1'b1);
        push_check(1'b1, {48'h2001_0DB8_0001, 80'h0}, 48, 32'd100, 1'b1);
        push_check(1'b1, 128'h0, 0, 32'd100, 1'b1);
        push_check(1'b1, {128{1'b1}}, 128, 32'd0, 1'b1);
        push_check(1'b1, {128{1'b1}}, 200, 32'd1, 1'b1);
        push_check(1'b1, {{127{1'b1}}, 1'b0}, 128, 32'd0, 1'b1);      // low word differs
        push_check(1'b1, {128{1'b1}}, 128, 32'd0, 1'b0);

        // --- fill every entry so that any entry_count reads written entries ---
        for (int i = 0; i < TABLE_ENTRIES; i++)
            push_random_load(i);

        // --- random phases, each under its own entry_count ---
        for (int p = 0; p < 10; p++) begin
            push_count(phase_counts[p]);
            n_use = (phase_counts[p] > TABLE_ENTRIES) ? TABLE_ENTRIES : phase_counts[p];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    push_random_load($urandom_range(0, TABLE_ENTRIES - 1));
                end else if (pick < 8 && n_use > 0) begin
                    // aim at an entry in use: equal, longer or shorter prefix
                    e    = $urandom_range(0, n_use - 1);
                    fam  = gen_fam[e];
                    maxl = fam ? 128 : 32;
                    el   = fit_len(int'(gen_len[e]), fam);
                    mode = $urandom_range(0, 9);
                    if (mode < 5)
                        ql = (el == maxl && $urandom_range(0, 1)) ?
                             $urandom_range(maxl, 255) : el;
                    else if (mode < 7)
                        ql = (el < maxl) ? $urandom_range(el + 1, maxl) : el;
                    else if (mode < 9)
                        ql = (el > 0) ? $urandom_range(0, el - 1) : 0;
                    else
                        ql = $urandom_range(0, 255);
                    qa = (gen_addr[e] & len_mask(8'(el))) | (rand128() & ~len_mask(8'(el)));
                    if ($urandom_range(0, 9) == 0) begin
                        flip = 127 - $urandom_range(0, maxl - 1);
                        qa[flip] = ~qa[flip];
                    end
                    asn = ($urandom_range(0, 9) < 6) ? gen_asn[e] : $urandom;
                    push_check(fam, qa, ql, asn, $urandom_range(0, 19) != 0);
                end else begin
                    // noise: any family, address, length and origin
                    push_check(1'($urandom_range(0, 1)), rand128(),
                               int'($urandom_range(0, 255)),
                               $urandom, $urandom_range(0, 4) != 0);
                end
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // everything offered, accepted and answered, then a quiet tail
        while (stim_q.size() != 0 || in_valid || pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d loads and %0d validations over %0d entry_count settings",
                 n_loads, n_checks, n_settings);
        $display("verdicts: unknown %0d, accept %0d, reject %0d, fail %0d",
                 verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3]);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rov_pkg.sv
rtl/rov_cell.sv
rtl/route_origin_validator.sv
rtl/rov_checker.sv
tb/tb.sv
